>>> design/fpr_pkg.sv
// Shared types and constants for the framed packet receiver.
`timescale 1ns / 1ps

package fpr_pkg;

   // Frame header and separator characters
   localparam logic [7:0] CHAR_U     = 8'h55;
   localparam logic [7:0] CHAR_N     = 8'h4E;
   localparam logic [7:0] CHAR_E     = 8'h45;
   localparam logic [7:0] CHAR_R     = 8'h52;
   localparam logic [7:0] CHAR_COLON = 8'h3A;

   // Checksum seed: header and separator, the length byte is folded in later
   localparam logic [7:0] HDR_SUM = CHAR_U ^ CHAR_N ^ CHAR_E ^ CHAR_R ^ CHAR_COLON;

   localparam logic [7:0] TIMEOUT_RESET = 8'd6;

   // Input beat kind (req_tuser)
   localparam logic MODE_BYTE = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   // Result kind (rsp_tuser)
   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_GOOD    = 2'd1,
      KIND_BADSUM  = 2'd2,
      KIND_ZEROLEN = 2'd3
   } kind_type;

   typedef enum logic [6:0] {
      PH_IDLE    = 7'b0000001,
      PH_HDR_N   = 7'b0000010,
      PH_HDR_E   = 7'b0000100,
      PH_HDR_R   = 7'b0001000,
      PH_LENGTH  = 7'b0010000,
      PH_TOKEN   = 7'b0100000,
      PH_PAYLOAD = 7'b1000000
   } phase_type;

endpackage

>>> design/framed_packet_receiver_top.sv
// Framed packet receiver: deframes 'UNER' length ':' payload checksum frames.
`timescale 1ns / 1ps

// Usage
//   req_*  : one beat per received byte (req_tuser = 0) or timer tick (req_tuser = 1).
//   rsp_*  : at most one result beat per input beat; payload bytes carry kind 0,
//            the checksum byte ends the frame with a good or bad verdict, a zero
//            length byte gives an error beat. rsp_tlast marks frame end or error.
//   csr_*  : timeout reload, ticks without bytes before the parser drops back to
//            idle; 0 disables. Write only while the block is idle.
// Timing
//   A result is registered and shows on rsp_* in the cycle after its beat is accepted.
//   One beat per cycle unless a result waits on a low rsp_tready; the parser state
//   and the output register are both updated in the accept cycle.
// Reset
//   Synchronous. Parser goes idle, output register empties, timeout reload 6.
// Stall
//   While a result waits on a low rsp_tready, req_tready is low; it rises in
//   the same cycle the waiting result is taken.
module framed_packet_receiver_top
   import fpr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tuser,   // [0] mode

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] data_byte, [15:8] byte_index,
                                    // [23:16] frame_length, [31:24] computed_sum
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast,

   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   logic [7:0] timeout_ff;
   phase_type  phase_ff, phase_in;
   logic [7:0] left_ff, left_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] pos_ff, pos_in;
   logic [7:0] len_ff, len_in;
   logic [7:0] count_ff, count_in;

   logic       out_valid_ff;
   kind_type   out_kind_ff, out_kind_in;
   logic [7:0] out_data_ff, out_data_in;
   logic [7:0] out_idx_ff, out_idx_in;
   logic [7:0] out_len_ff, out_len_in;
   logic [7:0] out_sum_ff, out_sum_in;
   logic       out_last_ff, out_last_in;
   logic       emit;

   logic       accept;
   logic [7:0] b;
   logic [7:0] pay_sum;
   phase_type  recheck;

   assign req_tready = !out_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign b          = req_tdata;
   assign pay_sum    = sum_ff ^ b;
   // on a mismatch the byte may itself start a new header
   assign recheck    = (b == CHAR_U) ? PH_HDR_N : PH_IDLE;

   always_comb begin
      phase_in    = phase_ff;
      left_in     = left_ff;
      sum_in      = sum_ff;
      pos_in      = pos_ff;
      len_in      = len_ff;
      count_in    = count_ff;
      emit        = 1'b0;
      out_kind_in = KIND_PAYLOAD;
      out_data_in = b;
      out_idx_in  = 8'd0;
      out_len_in  = len_ff;
      out_sum_in  = sum_ff;
      out_last_in = 1'b1;

      if (req_tuser == MODE_TICK) begin
         if (count_ff != 8'd0) begin
            count_in = count_ff - 8'd1;
            if (count_ff == 8'd1) begin
               phase_in = PH_IDLE;
            end
         end
      end else begin
         count_in = timeout_ff;
         case (phase_ff)
            PH_IDLE: begin
               if (b == CHAR_U) begin
                  phase_in = PH_HDR_N;
               end
            end
            PH_HDR_N: begin
               phase_in = (b == CHAR_N) ? PH_HDR_E : recheck;
            end
            PH_HDR_E: begin
               phase_in = (b == CHAR_E) ? PH_HDR_R : recheck;
            end
            PH_HDR_R: begin
               phase_in = (b == CHAR_R) ? PH_LENGTH : recheck;
            end
            PH_LENGTH: begin
               len_in = b;
               if (b == 8'd0) begin
                  phase_in    = PH_IDLE;
                  emit        = 1'b1;
                  out_kind_in = KIND_ZEROLEN;
                  out_data_in = 8'd0;
                  out_len_in  = 8'd0;
                  out_sum_in  = 8'd0;
               end else begin
                  phase_in = PH_TOKEN;
               end
            end
            PH_TOKEN: begin
               if (b == CHAR_COLON) begin
                  sum_in   = HDR_SUM ^ len_ff;
                  left_in  = len_ff;
                  pos_in   = 8'd1;
                  phase_in = PH_PAYLOAD;
               end else begin
                  phase_in = recheck;
               end
            end
            PH_PAYLOAD: begin
               emit = 1'b1;
               if (left_ff > 8'd1) begin
                  sum_in      = pay_sum;
                  pos_in      = pos_ff + 8'd1;
                  left_in     = left_ff - 8'd1;
                  out_idx_in  = pos_ff;
                  out_sum_in  = pay_sum;
                  out_last_in = 1'b0;
               end else begin
                  // checksum byte closes the frame
                  left_in     = 8'd0;
                  phase_in    = PH_IDLE;
                  out_kind_in = (sum_ff == b) ? KIND_GOOD : KIND_BADSUM;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= TIMEOUT_RESET;
         phase_ff     <= PH_IDLE;
         left_ff      <= 8'd0;
         sum_ff       <= 8'd0;
         pos_ff       <= 8'd0;
         len_ff       <= 8'd0;
         count_ff     <= 8'd0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
         if (accept) begin
            phase_ff     <= phase_in;
            left_ff      <= left_in;
            sum_ff       <= sum_in;
            pos_ff       <= pos_in;
            len_ff       <= len_in;
            count_ff     <= count_in;
            out_valid_ff <= emit;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // result payload, loaded only when a result is produced
   always_ff @(posedge clock) begin
      if (accept && emit) begin
         out_kind_ff <= out_kind_in;
         out_data_ff <= out_data_in;
         out_idx_ff  <= out_idx_in;
         out_len_ff  <= out_len_in;
         out_sum_ff  <= out_sum_in;
         out_last_ff <= out_last_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_sum_ff, out_len_ff, out_idx_ff, out_data_ff};
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

`ifndef SYNTH
   a_tick_no_result: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser == MODE_TICK) |=> !rsp_tvalid)
      else $error("tick beat produced a result");

   a_payload_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_PAYLOAD) |-> (!rsp_tlast && rsp_tdata[15:8] != 8'd0))
      else $error("payload result with last set or zero index");

   a_zerolen_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_ZEROLEN) |->
      (rsp_tlast && rsp_tdata[23:16] == 8'd0 && rsp_tdata[31:24] == 8'd0))
      else $error("zero length result carries nonzero length or sum");

   a_payload_left: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (left_ff != 8'd0))
      else $error("payload phase with no bytes left");
`endif

endmodule
